[src/crre_pkg.sv]
// Package for the clipped rectangle raster engine.
// Holds request codes, register indexes, the corner inset table and shared types.
// No dependencies.
package crre_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_RADIUS     = 10;

   localparam logic [2:0] REQ_FILL  = 3'd0;
   localparam logic [2:0] REQ_BLEND = 3'd1;
   localparam logic [2:0] REQ_GRAD  = 3'd2;
   localparam logic [2:0] REQ_READ  = 3'd3;
   localparam logic [2:0] REQ_WRITE = 3'd4;

   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_COLOR_ORDER   = 2'd2;
   localparam logic [1:0] REG_ENABLE        = 2'd3;

   // corner inset for radius r at corner row k
   function automatic logic [2:0] inset_lookup(input logic [3:0] r, input logic [3:0] k);
      logic [2:0] v;
      v = 3'd0;
      unique case (r)
         4'd2: v = (k == 4'd0) ? 3'd1 : 3'd0;
         4'd3: unique case (k) 4'd0: v = 3'd2; 4'd1: v = 3'd1; default: v = 3'd0; endcase
         4'd4: unique case (k) 4'd0: v = 3'd3; 4'd1: v = 3'd1; default: v = 3'd0; endcase
         4'd5: unique case (k)
                  4'd0: v = 3'd4; 4'd1: v = 3'd2; 4'd2: v = 3'd1; default: v = 3'd0;
               endcase
         4'd6: unique case (k)
                  4'd0: v = 3'd5; 4'd1: v = 3'd3; 4'd2: v = 3'd2; 4'd3: v = 3'd1;
                  default: v = 3'd0;
               endcase
         4'd7: unique case (k)
                  4'd0: v = 3'd4; 4'd1: v = 3'd2; 4'd2: v = 3'd1; 4'd3: v = 3'd1;
                  default: v = 3'd0;
               endcase
         4'd8, 4'd9: unique case (k)
                  4'd0: v = 3'd5; 4'd1: v = 3'd3; 4'd2: v = 3'd2; 4'd3: v = 3'd1;
                  4'd4: v = 3'd1; default: v = 3'd0;
               endcase
         4'd10: unique case (k)
                  4'd0: v = 3'd6; 4'd1: v = 3'd4; 4'd2: v = 3'd2; 4'd3: v = 3'd2;
                  4'd4: v = 3'd1; 4'd5: v = 3'd1; default: v = 3'd0;
               endcase
         default: v = 3'd0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] x_pos;
      logic [15:0] y_pos;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [3:0]  corner_radius;
      logic [31:0] color;
      logic [23:0] second_color;
      logic [7:0]  alpha;
   } req_type_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        ignored;
   } rsp_type;

   // start/done handshake to the divider
   typedef struct packed {
      logic        start;
      logic [17:0] dividend;
      logic [17:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic        done;
      logic [17:0] quotient;
   } div_sts_type;

endpackage

[src/crre_if.sv]
// Valid/ready channel interfaces for the raster engine.
// Depends on crre_pkg for the payload types.
interface crre_req_if (input logic clock);
   logic                       valid;
   logic                       ready;
   crre_pkg::req_type_type     req_payload;
   modport source (output valid, output req_payload, input ready);
   modport sink   (input valid, input req_payload, output ready);
endinterface

interface crre_rsp_if (input logic clock);
   logic               valid;
   logic               ready;
   crre_pkg::rsp_type  rsp_payload;
   modport source (output valid, output rsp_payload, input ready);
   modport sink   (input valid, input rsp_payload, output ready);
endinterface

[src/crre_div.sv]
// Restoring divider, one quotient bit per cycle, used by the engine for gradient rows.
// Depends on crre_pkg for the control structs.
module crre_div (
   input  logic                  clock,
   input  logic                  reset,
   input  crre_pkg::div_ctl_type ctl,
   output crre_pkg::div_sts_type sts
);
   localparam int W = 18;
   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] dvs_ff, dvs_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
      if (ctl.start) begin
         quo_in  = ctl.dividend;
         rem_in  = '0;
         dvs_in  = ctl.divisor;
         cnt_in  = 5'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[W]) begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;
endmodule

[src/clipped_rect_raster_engine.sv]
// Clipped rectangle raster engine, top level.
// Depends on crre_pkg, crre_if and crre_div.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves on rsp.
// Configuration is written through the csr APB port (width, height, color order,
// enable at byte addresses 0, 4, 8, 12); the user must write it only while the
// engine is idle, the block does not enforce this. After reset a clearing pass
// writes zero to every frame store word, one word a cycle; req_ready stays low.
// One request at a time: a setup state first, the result register last.
// Fill passes each row through a row state, then writes its covered pixels.
// Blend handles each covered pixel as read, read wait, one channel a cycle
// through the shared divide by 255, and write; each row starts in the row state.
// A gradient row computes t = i*255/hc on the 18-bit serial divider, then its
// color one channel a cycle, then writes each covered pixel.
// Pixel write stores in the pixel state; pixel read waits there for its data.
// The result sits in an output register; while rsp_ready is low the engine
// holds it and accepts no new request until it is taken.
module clipped_rect_raster_engine #(
   parameter int MAX_WIDTH  = crre_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = crre_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   crre_req_if.sink    req,
   crre_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

   typedef enum logic [11:0] {
      ST_CLEAR = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_SETUP = 12'b000000000100,
      ST_ROW   = 12'b000000001000,
      ST_GDIV  = 12'b000000010000,
      ST_GCH   = 12'b000000100000,
      ST_RD    = 12'b000001000000,
      ST_RDW   = 12'b000010000000,
      ST_BDIV  = 12'b000100000000,
      ST_WR    = 12'b001000000000,
      ST_PIX   = 12'b010000000000,
      ST_OUT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [8:0] scr_w_ff, scr_h_ff;
   logic       order_ff, enable_ff;

   crre_pkg::req_type_type cmd_ff, cmd_in;
   logic signed [17:0] x0_ff, x0_in, x1_ff, x1_in;   // clipped left edge, end column of current row
   logic signed [17:0] row_ff, row_in, y1_ff, y1_in;
   logic signed [17:0] gy0_ff, gy0_in;
   logic [XW-1:0] col_ff, col_in;
   logic [3:0]  rad_ff, rad_in;
   logic        any_ff, any_in;
   logic [31:0] px_ff, px_in;
   logic [31:0] dst_ff, dst_in;
   logic [1:0]  ch_ff, ch_in;
   logic [7:0]  t_ff, t_in;
   logic [23:0] acc_ff, acc_in;      // channel results, packed r,g,b
   logic [AW-1:0] clr_ff, clr_in;
   crre_pkg::rsp_type out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   // gradient multiplier operands and product, combinational
   logic signed [17:0] mul_prod;
   logic signed [8:0]  mul_a;
   logic [7:0]         mul_b;

   crre_pkg::div_ctl_type div_ctl;
   crre_pkg::div_sts_type div_sts;

   crre_div u_div (.clock(clock), .reset(reset), .ctl(div_ctl), .sts(div_sts));

   // frame store
   logic [31:0]   mem [DEPTH];
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [31:0]   mem_wdata;
   logic [31:0]   mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_addr];
   end

   // configuration port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff  <= 9'd256;
         scr_h_ff  <= 9'd256;
         order_ff  <= 1'b0;
         enable_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            crre_pkg::REG_SCREEN_WIDTH:  scr_w_ff  <= csr_pwdata[8:0];
            crre_pkg::REG_SCREEN_HEIGHT: scr_h_ff  <= csr_pwdata[8:0];
            crre_pkg::REG_COLOR_ORDER:   order_ff  <= csr_pwdata[0];
            crre_pkg::REG_ENABLE:        enable_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         crre_pkg::REG_SCREEN_WIDTH:  csr_prdata = {23'd0, scr_w_ff};
         crre_pkg::REG_SCREEN_HEIGHT: csr_prdata = {23'd0, scr_h_ff};
         crre_pkg::REG_COLOR_ORDER:   csr_prdata = {31'd0, order_ff};
         crre_pkg::REG_ENABLE:        csr_prdata = {31'd0, enable_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // effective screen size, saturated
   logic signed [17:0] sw, sh;
   assign sw = (32'(scr_w_ff) > MAX_WIDTH)  ? 18'(MAX_WIDTH)  : 18'(scr_w_ff);
   assign sh = (32'(scr_h_ff) > MAX_HEIGHT) ? 18'(MAX_HEIGHT) : 18'(scr_h_ff);

   function automatic logic [31:0] pack(input logic ord, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
      return ord ? {8'd0, b, g, r} : {8'd0, r, g, b};
   endfunction

   // request fields, positions sign extended and sizes zero extended
   logic signed [17:0] cx, cy, cw, ch;
   assign cx = 18'(signed'(cmd_ff.x_pos));
   assign cy = 18'(signed'(cmd_ff.y_pos));
   assign cw = 18'({2'b00, cmd_ff.rect_width});
   assign ch = 18'({2'b00, cmd_ff.rect_height});

   // per-row span for round rects
   logic signed [17:0] rel, kidx, ra, xs, xe;
   logic [2:0] ins;
   always_comb begin
      rel  = row_ff - cy;
      kidx = '0;
      ins  = 3'd0;
      ra   = 18'({14'd0, rad_ff});
      if (rel < ra) begin
         kidx = rel;
         ins  = crre_pkg::inset_lookup(rad_ff, kidx[3:0]);
      end else if (rel >= ch - ra) begin
         kidx = ch - 18'sd1 - rel;
         ins  = crre_pkg::inset_lookup(rad_ff, kidx[3:0]);
      end
      xs = cx + 18'(ins);
      xe = cx + cw - 18'(ins);
      if (xs < 0) xs = '0;
      if (xe > sw) xe = sw;
   end

   // channel selection for blend and gradient
   logic [7:0] src_c, dst_c, top_c, bot_c;
   always_comb begin
      unique case (ch_ff)
         2'd0: begin
            src_c = cmd_ff.color[23:16];
            dst_c = order_ff ? dst_ff[7:0] : dst_ff[23:16];
            top_c = cmd_ff.color[23:16];
            bot_c = cmd_ff.second_color[23:16];
         end
         2'd1: begin
            src_c = cmd_ff.color[15:8];
            dst_c = dst_ff[15:8];
            top_c = cmd_ff.color[15:8];
            bot_c = cmd_ff.second_color[15:8];
         end
         default: begin
            src_c = cmd_ff.color[7:0];
            dst_c = order_ff ? dst_ff[23:16] : dst_ff[7:0];
            top_c = cmd_ff.color[7:0];
            bot_c = cmd_ff.second_color[7:0];
         end
      endcase
   end

   // blend numerator and gradient delta*t
   logic [16:0] blend_num;
   logic signed [8:0] gdelta;
   logic [17:0] gmag;
   logic gneg;
   assign blend_num = 17'(dst_c) * 17'(8'd255 - cmd_ff.alpha)
                    + 17'(src_c) * 17'(cmd_ff.alpha) + 17'd127;
   assign gdelta = 9'(signed'({1'b0, bot_c})) - 9'(signed'({1'b0, top_c}));
   assign mul_a  = gdelta;
   assign mul_b  = t_ff;
   assign mul_prod = 18'(mul_a) * 18'(signed'({1'b0, mul_b}));
   assign gneg = mul_prod < 0;
   assign gmag = gneg ? 18'(-mul_prod) : 18'(mul_prod);

   // shared divide by 255: (n + (n >> 8) + 1) >> 8 is exact for n below 65535
   logic [16:0] d255_num;
   logic [17:0] d255_sum;
   logic [7:0]  gres, q8;
   assign d255_num = (state_ff == ST_GCH) ? gmag[16:0] : blend_num;
   assign d255_sum = 18'(d255_num) + 18'(d255_num[16:8]) + 18'd1;
   assign q8   = d255_sum[15:8];
   assign gres = gneg ? top_c - q8 : top_c + q8;

   logic pix_on_screen;
   assign pix_on_screen = !cx[17] && !cy[17] && cx < sw && cy < sh;

   logic [AW-1:0] pix_addr, cell_addr, pt_addr;
   assign cell_addr = {row_ff[YW-1:0], col_ff};
   assign pt_addr   = {cy[YW-1:0], cx[XW-1:0]};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      row_in       = row_ff;
      y1_in        = y1_ff;
      gy0_in       = gy0_ff;
      col_in       = col_ff;
      rad_in       = rad_ff;
      any_in       = any_ff;
      px_in        = px_ff;
      dst_in       = dst_ff;
      ch_in        = ch_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      clr_in       = clr_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      mem_we       = 1'b0;
      mem_addr     = cell_addr;
      mem_wdata    = px_ff;
      div_ctl      = '0;
      pix_addr     = pt_addr;
      req.ready    = 1'b0;

      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req.ready = !out_valid_ff;
            if (req.valid && !out_valid_ff) begin
               cmd_in   = req.req_payload;
               any_in   = 1'b0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // clamp radius, clip rows and columns, pick the next state
            rad_in = (cmd_ff.corner_radius > 4'(crre_pkg::MAX_RADIUS))
                     ? 4'(crre_pkg::MAX_RADIUS) : cmd_ff.corner_radius;
            if (18'(rad_in) > (ch >>> 1)) rad_in = ch[4:1];
            if (18'(rad_in) > (cw >>> 1)) rad_in = cw[4:1];
            row_in = cy[17] ? '0 : cy;
            y1_in  = (cy + ch > sh) ? sh : cy + ch;
            gy0_in = row_in;
            px_in  = pack(order_ff, cmd_ff.color[23:16], cmd_ff.color[15:8],
                          cmd_ff.color[7:0]);
            x0_in  = cx[17] ? '0 : cx;
            x1_in  = (cx + cw > sw) ? sw : cx + cw;
            state_in = ST_OUT;
            out_in   = '{read_data: 32'd0, ignored: 1'b1};
            if (enable_ff) begin
               priority case (1'b1)
                  cmd_ff.req_type == crre_pkg::REQ_FILL,
                  cmd_ff.req_type == crre_pkg::REQ_BLEND: state_in = ST_ROW;
                  cmd_ff.req_type == crre_pkg::REQ_GRAD: begin
                     if (ch != 0 && x1_in > x0_in && y1_in > row_in) state_in = ST_GDIV;
                  end
                  cmd_ff.req_type == crre_pkg::REQ_READ,
                  cmd_ff.req_type == crre_pkg::REQ_WRITE: begin
                     if (pix_on_screen) state_in = ST_PIX;
                  end
                  default: ;
               endcase
            end
            if (state_in == ST_GDIV) begin
               div_ctl.start    = 1'b1;
               div_ctl.dividend = 18'((row_in - row_in) * 255);
               div_ctl.divisor  = y1_in - row_in;
               ch_in            = 2'd0;
               acc_in           = '0;
            end
         end
         ST_ROW: begin
            // start the next row of a fill or blend, or finish after the last row
            if (row_ff >= y1_ff) begin
               out_in   = '{read_data: 32'd0, ignored: !any_ff};
               state_in = ST_OUT;
            end else if (xs >= xe) begin
               row_in = row_ff + 18'sd1;
            end else begin
               x1_in  = xe;
               col_in = xs[XW-1:0];
               if (cmd_ff.req_type == crre_pkg::REQ_BLEND) state_in = ST_RD;
               else state_in = ST_WR;
            end
         end
         ST_RD: begin
            state_in = ST_RDW;   // address presented, data next cycle
         end
         ST_RDW: begin
            dst_in   = mem_rdata_ff;
            ch_in    = 2'd0;
            state_in = ST_BDIV;
         end
         ST_BDIV: begin
            // one channel a cycle through the shared divide by 255
            acc_in = {acc_ff[15:0], q8};
            if (ch_ff == 2'd2) begin
               px_in    = pack(order_ff, acc_ff[15:8], acc_ff[7:0], q8);
               state_in = ST_WR;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_WR: begin
            mem_we = 1'b1;
            any_in = 1'b1;
            if (18'(col_ff) + 18'sd1 >= x1_ff) begin
               row_in = row_ff + 18'sd1;
               if (cmd_ff.req_type == crre_pkg::REQ_GRAD) begin
                  if (row_in >= y1_ff) begin
                     out_in   = '{read_data: 32'd0, ignored: 1'b0};
                     state_in = ST_OUT;
                  end else begin
                     col_in           = x0_ff[XW-1:0];
                     div_ctl.start    = 1'b1;
                     div_ctl.dividend = 18'((row_in - gy0_ff) * 255);
                     div_ctl.divisor  = y1_ff - gy0_ff;
                     ch_in            = 2'd0;
                     state_in         = ST_GDIV;
                  end
               end else begin
                  state_in = ST_ROW;
               end
            end else begin
               col_in = col_ff + 1'b1;
               if (cmd_ff.req_type == crre_pkg::REQ_BLEND) state_in = ST_RD;
            end
         end
         ST_GDIV: begin
            // t = i*255/hc
            if (div_sts.done) begin
               t_in     = div_sts.quotient[7:0];
               state_in = ST_GCH;
               ch_in    = 2'd0;
            end
         end
         ST_GCH: begin
            // per channel |delta*t|/255, one channel a cycle
            acc_in = {acc_ff[15:0], gres};
            if (ch_ff == 2'd2) begin
               px_in    = pack(order_ff, acc_ff[15:8], acc_ff[7:0], gres);
               col_in   = x0_ff[XW-1:0];
               state_in = ST_WR;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_PIX: begin
            mem_addr = pix_addr;
            if (cmd_ff.req_type == crre_pkg::REQ_WRITE) begin
               mem_we    = 1'b1;
               mem_wdata = cmd_ff.color;
               out_in    = '{read_data: 32'd0, ignored: 1'b0};
               state_in  = ST_OUT;
            end else if (any_ff) begin
               out_in   = '{read_data: mem_rdata_ff, ignored: 1'b0};
               state_in = ST_OUT;
            end else begin
               any_in = 1'b1;   // wait for the registered read data
            end
         end
         ST_OUT: begin
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff <= cmd_in;
      x0_ff  <= x0_in;
      x1_ff  <= x1_in;
      row_ff <= row_in;
      y1_ff  <= y1_in;
      gy0_ff <= gy0_in;
      col_ff <= col_in;
      rad_ff <= rad_in;
      any_ff <= any_in;
      px_ff  <= px_in;
      dst_ff <= dst_in;
      ch_ff  <= ch_in;
      t_ff   <= t_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.rsp_payload = out_ff;

   logic unused_ok;
   assign unused_ok = ^{gmag[17], d255_sum[17:16], d255_sum[7:0], div_sts.quotient[17:8]};
endmodule

[src/crre_checker.sv]
// Port-level checker for the raster engine, bound to the top level.
// Depends on the top level's port list only.
module crre_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] rsp_data,
   input logic rsp_ignored
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   a_ignored_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_data == 32'd0)
      else $error("ignored response carries data");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response in the cycle after a request");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");
endmodule

bind clipped_rect_raster_engine crre_checker u_crre_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_data(rsp.rsp_payload.read_data),
   .rsp_ignored(rsp.rsp_payload.ignored)
);
